### hdl/mvt_pkg.sv
`timescale 1ns / 1ps
package mvt_pkg;

    // Message kinds (high nibble of the status byte).
    localparam logic [3:0] KIND_OFF  = 4'h8;
    localparam logic [3:0] KIND_ON   = 4'h9;
    localparam logic [3:0] KIND_POLY = 4'hA;
    localparam logic [3:0] KIND_CTRL = 4'hB;
    localparam logic [3:0] KIND_BEND = 4'hE;

    // Controller numbers with fixed meaning.
    localparam logic [6:0] CC_DATA_MSB = 7'd6;
    localparam logic [6:0] CC_DATA_LSB = 7'd38;
    localparam logic [6:0] CC_RPN_LSB  = 7'd100;
    localparam logic [6:0] CC_RPN_MSB  = 7'd101;

    // Configuration register indexes.
    localparam logic CFG_PRESSURE = 1'b0;
    localparam logic CFG_TIMBRE   = 1'b1;

    localparam logic [13:0] BEND_CENTER  = 14'h2000;
    localparam logic [13:0] RANGE_RESET  = 14'd200;

    // Per-voice record held in the voice memory.
    typedef struct packed {
        logic [3:0]  channel;
        logic [6:0]  key;
        logic [15:0] serial;
        logic [13:0] pressure;
        logic [13:0] timbre;
        logic [6:0]  pressure_low;
        logic [6:0]  timbre_low;
    } t_voice;

    // Per-channel record held in the channel memory.
    typedef struct packed {
        logic signed [14:0] bend;
        logic [13:0]        rpn;
        logic [13:0]        data;
        logic [13:0]        range;
    } t_chan;

endpackage

### hdl/midi_voice_tracker_unit.sv
`timescale 1ns / 1ps
// MIDI voice tracker. A request carries one three-byte channel message and is
// taken at a clock edge where start is high and busy is low. Note-off, poly
// pressure, pitch bend, data-entry MSB and every controller other than the RPN
// numbers and the data-entry LSB scan the voice memory one slot per cycle. The
// next request can then be taken once the channel record is read, the scan
// has covered every slot, the pitch pipeline has drained and the block has
// gone back to idle. Note-on, RPN writes, data-entry LSB writes and ignored
// kinds skip the scan. Each result appears for one cycle with o_valid high,
// and o_last marks the final result of a message. The receiver cannot stall,
// so results must be taken as they come. busy stays high until the final
// result is on the ports. Configuration writes take effect at once and are
// allowed while the block is idle.
module midi_voice_tracker_unit
    import mvt_pkg::*;
#(
    parameter int VOICES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_data,
    input  logic [7:0]         i_status_byte,
    input  logic [6:0]         i_data_one,
    input  logic [6:0]         i_data_two,
    output logic               o_valid,
    output logic               o_event_kind,
    output logic [3:0]         o_voice_slot,
    output logic [15:0]        o_voice_tag,
    output logic [3:0]         o_zone,
    output logic signed [16:0] o_pitch,
    output logic [13:0]        o_pressure,
    output logic [13:0]        o_timbre,
    output logic               o_last
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_CHRD, S_SCAN, S_ACT, S_DRAIN
    } t_state;

    t_state r_state;
    logic [6:0]  r_pctl, r_tctl;
    logic [7:0]  r_status;
    logic [6:0]  r_d1, r_d2;
    logic [15:0] r_serial;
    logic [VOICES-1:0] r_valid;
    logic [VW:0] r_idx;
    logic        r_rd_ok;       // voice read data belongs to slot r_idx-1
    logic        r_done;        // single-target message already handled
    t_chan       r_ch;
    logic [2:0]  r_drain;

    // Voice memory and channel memory, synchronous read.
    t_voice r_vmem [VOICES];
    t_voice r_vrd;
    t_chan  r_cmem [16];
    t_chan  r_crd;
    logic [15:0] r_cinit;      // channel entry written since reset
    logic [3:0]  w_ch;
    assign w_ch = r_status[3:0];

    logic [VW-1:0] w_slot;
    assign w_slot = VW'(r_idx - 1'b1);

    // Emission pipeline: a result record passes through r_e0, r_e1 and r_e2 while the pitch is computed.
    logic       r_e0, r_e1, r_e2;
    logic       r_k0, r_k1, r_k2;
    logic [3:0] r_s0, r_s1, r_s2;
    logic [15:0] r_t0, r_t1, r_t2;
    logic [3:0] r_z0, r_z1, r_z2;
    logic [13:0] r_p0, r_p1, r_p2, r_b0, r_b1, r_b2;
    logic [6:0] r_key;
    logic signed [14:0] r_bend;
    logic [13:0] r_range;
    logic signed [16:0] w_pitch;

    mvt_pitch u_pitch (
        .i_clk(i_clk), .i_key(r_key), .i_bend(r_bend), .i_range(r_range),
        .o_pitch(w_pitch)
    );

    // Message decode.
    logic [3:0] w_kind;
    logic       w_cc_fixed, w_pl, w_pm, w_tl, w_tm;
    assign w_kind = r_status[7:4];
    always_comb begin
        w_cc_fixed = (r_d1 == CC_DATA_MSB) || (r_d1 == CC_DATA_LSB) ||
                     (r_d1 == CC_RPN_LSB) || (r_d1 == CC_RPN_MSB);
        w_pl = (8'(r_d1) == 8'(r_pctl) + 8'd32);
        w_pm = !w_pl && (r_d1 == r_pctl);
        w_tl = !w_pl && !w_pm && (8'(r_d1) == 8'(r_tctl) + 8'd32);
        w_tm = !w_pl && !w_pm && !w_tl && (r_d1 == r_tctl);
    end

    t_chan w_cur;
    assign w_cur = r_cinit[w_ch] ? r_crd
                                 : '{bend: 15'sd0, rpn: 14'd0, data: 14'd0, range: RANGE_RESET};

    // Per-slot action on the voice just read.
    t_voice w_wr;
    logic   w_match, w_we, w_emit, w_kill, w_kindrel;
    always_comb begin
        w_wr = r_vrd;
        w_we = 1'b0; w_emit = 1'b0; w_kill = 1'b0; w_kindrel = 1'b0;
        w_match = r_rd_ok && r_valid[w_slot] && r_vrd.channel == w_ch;
        case (w_kind)
            KIND_OFF, KIND_POLY: begin
                if (w_match && r_vrd.key == r_d1 && !r_done) begin
                    w_emit = 1'b1;
                    if (w_kind == KIND_OFF) begin
                        w_kill = 1'b1; w_kindrel = 1'b1;
                    end else begin
                        w_we = 1'b1;
                        w_wr.pressure = 14'(r_d2) * 14'd129;
                    end
                end
            end
            KIND_BEND: w_emit = w_match;
            KIND_CTRL: begin
                if (w_cc_fixed) begin
                    w_emit = w_match && r_d1 == CC_DATA_MSB && r_ch.rpn == 14'd0;
                end else if (w_match) begin
                    w_we = 1'b1;
                    if (w_pl) w_wr.pressure_low = r_d2;
                    else if (w_pm) begin
                        w_wr.pressure = {r_d2, r_vrd.pressure_low}; w_emit = 1'b1;
                    end else if (w_tl) w_wr.timbre_low = r_d2;
                    else if (w_tm) begin
                        w_wr.timbre = {r_d2, r_vrd.timbre_low}; w_emit = 1'b1;
                    end else w_we = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // First free slot for note-on.
    logic [VW-1:0] w_free;
    logic          w_has_free;
    always_comb begin
        w_free = '0; w_has_free = 1'b0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free = VW'(i); w_has_free = 1'b1;
            end
        end
    end

    logic w_scan_end;
    assign w_scan_end = (r_idx == (VW+1)'(VOICES));

    // Control and emission.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_pctl <= '0; r_tctl <= '0; r_serial <= '0;
            r_valid <= '0; r_cinit <= '0; r_e0 <= 1'b0; r_e1 <= 1'b0;
            r_e2 <= 1'b0; r_rd_ok <= 1'b0; r_done <= 1'b0; r_idx <= '0;
            r_drain <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_PRESSURE) r_pctl <= i_cfg_data;
                else r_tctl <= i_cfg_data;
            end
            r_e0 <= 1'b0; r_e1 <= r_e0; r_e2 <= r_e1;
            r_k1 <= r_k0; r_s1 <= r_s0; r_t1 <= r_t0; r_z1 <= r_z0;
            r_p1 <= r_p0; r_b1 <= r_b0;
            r_k2 <= r_k1; r_s2 <= r_s1; r_t2 <= r_t1; r_z2 <= r_z1;
            r_p2 <= r_p1; r_b2 <= r_b1;
            case (r_state)
                S_IDLE: if (start) begin
                    r_status <= i_status_byte; r_d1 <= i_data_one;
                    r_d2 <= i_data_two; r_state <= S_CHRD;
                    r_crd <= r_cmem[i_status_byte[3:0]];
                end
                S_CHRD: begin
                    // Update channel record, then begin the scan for the kinds that need one.
                    r_ch <= w_cur;
                    r_idx <= '0; r_rd_ok <= 1'b0; r_done <= 1'b0;
                    r_state <= S_SCAN;
                    case (w_kind)
                        KIND_BEND: begin
                            r_cmem[w_ch] <= '{bend: $signed({1'b0, r_d2, r_d1}) - 15'sd8192,
                                rpn: w_cur.rpn, data: w_cur.data, range: w_cur.range};
                            r_ch.bend <= $signed({1'b0, r_d2, r_d1}) - 15'sd8192;
                            r_cinit[w_ch] <= 1'b1;
                        end
                        KIND_CTRL: begin
                            if (r_d1 == CC_RPN_LSB || r_d1 == CC_RPN_MSB ||
                                r_d1 == CC_DATA_LSB || r_d1 == CC_DATA_MSB) begin
                                r_cinit[w_ch] <= 1'b1;
                                if (r_d1 == CC_RPN_LSB)
                                    r_cmem[w_ch] <= '{bend: w_cur.bend,
                                        rpn: {w_cur.rpn[13:7], r_d2}, data: w_cur.data,
                                        range: w_cur.range};
                                else if (r_d1 == CC_RPN_MSB)
                                    r_cmem[w_ch] <= '{bend: w_cur.bend,
                                        rpn: {r_d2, w_cur.rpn[6:0]}, data: w_cur.data,
                                        range: w_cur.range};
                                else if (r_d1 == CC_DATA_LSB)
                                    r_cmem[w_ch] <= '{bend: w_cur.bend, rpn: w_cur.rpn,
                                        data: {w_cur.data[13:7], r_d2}, range: w_cur.range};
                                else begin
                                    r_cmem[w_ch] <= '{bend: w_cur.bend, rpn: w_cur.rpn,
                                        data: {r_d2, w_cur.data[6:0]},
                                        range: (w_cur.rpn == 14'd0) ?
                                            14'(r_d2 * 14'd100 + 14'(w_cur.data[6:0]))
                                            : w_cur.range};
                                    if (w_cur.rpn == 14'd0)
                                        r_ch.range <= 14'(r_d2 * 14'd100 +
                                                          14'(w_cur.data[6:0]));
                                end
                                if (r_d1 != CC_DATA_MSB) r_state <= S_DRAIN;
                            end
                        end
                        KIND_ON: begin
                            r_state <= S_DRAIN;
                            if (w_has_free) begin
                                r_valid[w_free] <= 1'b1;
                                r_vmem[w_free] <= '{channel: w_ch, key: r_d1,
                                    serial: r_serial, pressure: 14'(r_d2) * 14'd129,
                                    timbre: '0, pressure_low: '0, timbre_low: '0};
                                r_serial <= r_serial + 16'd1;
                                r_e0 <= 1'b1; r_k0 <= 1'b0; r_s0 <= 4'(w_free);
                                r_t0 <= r_serial; r_z0 <= w_ch;
                                r_p0 <= 14'(r_d2) * 14'd129; r_b0 <= '0;
                                r_key <= r_d1; r_bend <= w_cur.bend;
                                r_range <= w_cur.range;
                            end
                        end
                        KIND_OFF, KIND_POLY: ;
                        default: r_state <= S_DRAIN;
                    endcase
                    r_drain <= '0;
                end
                S_SCAN: begin
                    // Read slot r_idx; act on slot r_idx-1.
                    if (!w_scan_end) r_vrd <= r_vmem[VW'(r_idx)];
                    r_rd_ok <= !w_scan_end;
                    r_idx <= r_idx + 1'b1;
                    if (r_rd_ok) begin
                        if (w_we) r_vmem[w_slot] <= w_wr;
                        if (w_kill) r_valid[w_slot] <= 1'b0;
                        if (w_emit) begin
                            r_done <= 1'b1;
                            r_e0 <= 1'b1; r_k0 <= w_kindrel;
                            r_s0 <= 4'(w_slot); r_t0 <= r_vrd.serial;
                            r_z0 <= r_vrd.channel; r_p0 <= w_wr.pressure;
                            r_b0 <= w_wr.timbre; r_key <= r_vrd.key;
                            r_bend <= r_ch.bend; r_range <= r_ch.range;
                        end
                    end
                    // The last slot is handled in the cycle that ends the scan.
                    if (w_scan_end) begin
                        r_state <= S_DRAIN; r_drain <= '0;
                    end
                end
                S_DRAIN: begin
                    r_drain <= r_drain + 3'd1;
                    if (r_drain == 3'd3) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output stage holds one result back so that the last flag is known.
    logic r_hv;
    logic r_hk; logic [3:0] r_hs, r_hz; logic [15:0] r_ht;
    logic signed [16:0] r_hp; logic [13:0] r_hpr, r_htb;
    logic w_more;
    assign w_more = r_e0 || r_e1 || r_e2 || (r_state == S_SCAN) || (r_state == S_CHRD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0; o_valid <= 1'b0; o_last <= 1'b0;
        end else begin
            o_valid <= 1'b0; o_last <= 1'b0;
            if (r_e2) begin
                r_hv <= 1'b1; r_hk <= r_k2; r_hs <= r_s2; r_ht <= r_t2;
                r_hz <= r_z2; r_hp <= w_pitch; r_hpr <= r_p2; r_htb <= r_b2;
            end else if (r_hv && !w_more) begin
                r_hv <= 1'b0;
            end
            if (r_hv && (r_e2 || !w_more)) begin
                o_valid <= 1'b1; o_last <= !r_e2;
                o_event_kind <= r_hk; o_voice_slot <= r_hs; o_voice_tag <= r_ht;
                o_zone <= r_hz; o_pitch <= r_hp; o_pressure <= r_hpr;
                o_timbre <= r_htb;
            end
        end
    end

    assign busy = (r_state != S_IDLE) || r_hv;

`ifndef SYNTH
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid) else $error("last without valid");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request not taken");
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e0 |-> busy) else $error("result while idle");
`endif

endmodule

### hdl/mvt_pitch.sv
`timescale 1ns / 1ps
module mvt_pitch
    import mvt_pkg::*;
(
    input  logic               i_clk,
    input  logic [6:0]         i_key,
    input  logic signed [14:0] i_bend,
    input  logic [13:0]        i_range,
    output logic signed [16:0] o_pitch
);

    // Stage one: bend times range, a 15 by 15 signed product.
    logic signed [29:0] r_prod;
    logic [6:0]         r_key;
    // Stage two: divide by 3200 through a reciprocal, then correct.
    logic signed [29:0] r_quot;
    logic signed [29:0] r_rem;
    logic [6:0]         r_key2;
    logic               r_neg;

    logic [28:0] w_mag;
    logic [57:0] w_mul;
    logic [28:0] w_q;
    logic [29:0] w_r;

    always_comb begin
        w_mag = r_prod[29] ? 29'(-r_prod) : r_prod[28:0];
        // ceil(2^42/3200); exact for magnitudes below 2^28.
        w_mul = 58'(w_mag) * 58'd1374389535;
        w_q   = 29'(w_mul >> 42);
        w_r   = 30'(w_mag) - 30'(w_q) * 30'd3200;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 30'(i_bend) * 30'($signed({1'b0, i_range}));
        r_key  <= i_key;
        r_quot <= 30'(w_q);
        r_rem  <= $signed(w_r);
        r_neg  <= r_prod[29];
        r_key2 <= r_key;
    end

    logic [28:0] w_qc;
    always_comb begin
        w_qc = (r_rem >= 30'sd3200) ? 29'(r_quot + 30'sd1) : r_quot[28:0];
        o_pitch = 17'({r_key2, 8'd0}) + (r_neg ? -$signed(17'(w_qc)) : $signed(17'(w_qc)));
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import mvt_pkg::*;

    localparam int NVOICE = 16;
    localparam int LATENCY = 40;
    localparam int CYCLE_LIMIT = 400000;

    // Message kinds that the block ignores.
    localparam logic [3:0] KIND_PROG = 4'hC;
    localparam logic [3:0] KIND_SYS  = 4'hF;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
    } t_msg;

    typedef struct packed {
        logic        kind;
        logic [3:0]  slot;
        logic [15:0] tag;
        logic [3:0]  zone;
        logic [16:0] pitch;
        logic [13:0] pressure;
        logic [13:0] timbre;
        logic        last;
    } t_event;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [6:0]  i_cfg_data;
    logic [7:0]  i_status_byte;
    logic [6:0]  i_data_one;
    logic [6:0]  i_data_two;
    logic        o_valid;
    logic        o_event_kind;
    logic [3:0]  o_voice_slot;
    logic [15:0] o_voice_tag;
    logic [3:0]  o_zone;
    logic signed [16:0] o_pitch;
    logic [13:0] o_pressure;
    logic [13:0] o_timbre;
    logic        o_last;

    midi_voice_tracker_unit u_top (.*);

    // Predictor state.
    logic [6:0]  pr_ctl, tb_ctl;
    logic        v_on[NVOICE];
    logic [3:0]  v_ch[NVOICE];
    logic [6:0]  v_key[NVOICE];
    logic [15:0] v_tag[NVOICE];
    logic [13:0] v_pres[NVOICE];
    logic [13:0] v_timb[NVOICE];
    logic [6:0]  v_plo[NVOICE];
    logic [6:0]  v_tlo[NVOICE];
    logic [15:0] tag_next;
    int          ch_bend[16];
    logic [13:0] ch_rpn[16];
    logic [13:0] ch_data[16];
    int          ch_range[16];

    t_msg   pending_msgs[$];
    t_event expected_events[$];
    int     errors;
    int     cycles;
    bit     hold_sender;

    // Voice event as the block should report it.
    function automatic t_event voice_event(logic kind, int v);
        t_event e;
        longint off;
        off = longint'(ch_bend[v_ch[v]]) * ch_range[v_ch[v]] / 3200;
        e.kind = kind;
        e.slot = v[3:0];
        e.tag = v_tag[v];
        e.zone = v_ch[v];
        e.pitch = 17'(longint'(v_key[v]) * 256 + off);
        e.pressure = v_pres[v];
        e.timbre = v_timb[v];
        e.last = 1'b0;
        return e;
    endfunction

    function automatic void emit_channel(logic [3:0] ch, ref t_event evs[$]);
        for (int v = 0; v < NVOICE; v++)
            if (v_on[v] && v_ch[v] == ch) evs.push_back(voice_event(1'b0, v));
    endfunction

    function automatic int find_voice(logic [3:0] ch, logic [6:0] key);
        for (int v = 0; v < NVOICE; v++)
            if (v_on[v] && v_ch[v] == ch && v_key[v] == key) return v;
        return -1;
    endfunction

    // Applies one message to the voice table and queues the resulting events.
    function automatic void track_message(t_msg m);
        t_event evs[$];
        logic [3:0] ch;
        int s;
        int n;
        ch = m.status[3:0];
        case (m.status[7:4])
            KIND_ON: begin
                s = -1;
                for (int v = NVOICE - 1; v >= 0; v--) if (!v_on[v]) s = v;
                if (s >= 0) begin
                    v_on[s] = 1'b1;
                    v_ch[s] = ch;
                    v_key[s] = m.d1;
                    v_tag[s] = tag_next;
                    tag_next++;
                    v_pres[s] = 14'(m.d2 * 129);
                    v_timb[s] = '0;
                    v_plo[s] = '0;
                    v_tlo[s] = '0;
                    evs.push_back(voice_event(1'b0, s));
                end
            end
            KIND_OFF: begin
                s = find_voice(ch, m.d1);
                if (s >= 0) begin
                    v_on[s] = 1'b0;
                    evs.push_back(voice_event(1'b1, s));
                end
            end
            KIND_POLY: begin
                s = find_voice(ch, m.d1);
                if (s >= 0) begin
                    v_pres[s] = 14'(m.d2 * 129);
                    evs.push_back(voice_event(1'b0, s));
                end
            end
            KIND_BEND: begin
                ch_bend[ch] = int'({m.d2, m.d1}) - 8192;
                emit_channel(ch, evs);
            end
            KIND_CTRL: begin
                if (m.d1 == CC_RPN_LSB) ch_rpn[ch][6:0] = m.d2;
                else if (m.d1 == CC_RPN_MSB) ch_rpn[ch][13:7] = m.d2;
                else if (m.d1 == CC_DATA_LSB) ch_data[ch][6:0] = m.d2;
                else if (m.d1 == CC_DATA_MSB) begin
                    ch_data[ch][13:7] = m.d2;
                    if (ch_rpn[ch] == 0) begin
                        ch_range[ch] = ch_data[ch][13:7] * 100 + ch_data[ch][6:0];
                        emit_channel(ch, evs);
                    end
                end else begin
                    for (int v = 0; v < NVOICE; v++) begin
                        if (!v_on[v] || v_ch[v] != ch) continue;
                        if (int'(m.d1) == int'(pr_ctl) + 32) v_plo[v] = m.d2;
                        else if (m.d1 == pr_ctl) begin
                            v_pres[v] = {m.d2, v_plo[v]};
                            evs.push_back(voice_event(1'b0, v));
                        end else if (int'(m.d1) == int'(tb_ctl) + 32) v_tlo[v] = m.d2;
                        else if (m.d1 == tb_ctl) begin
                            v_timb[v] = {m.d2, v_tlo[v]};
                            evs.push_back(voice_event(1'b0, v));
                        end
                    end
                end
            end
            default: ;
        endcase
        n = evs.size();
        if (n > 0) evs[n - 1].last = 1'b1;
        foreach (evs[i]) expected_events.push_back(evs[i]);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: bursts of requests with random gaps.
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (start && !busy) begin
            track_message({i_status_byte, i_data_one, i_data_two});
            start <= 1'b0;
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_msgs.size() > 0 && !hold_sender) begin
                t_msg m;
                m = pending_msgs.pop_front();
                i_status_byte <= m.status;
                i_data_one <= m.d1;
                i_data_two <= m.d2;
                start <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
        end
    end

    // Monitor: each strobed event is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_events.size() == 0) begin
                $error("unexpected event slot %0d tag %0d", o_voice_slot, o_voice_tag);
                errors++;
            end else begin
                t_event e;
                e = expected_events.pop_front();
                if (o_event_kind !== e.kind) begin
                    $error("event_kind exp %0h got %0h", e.kind, o_event_kind); errors++;
                end
                if (o_voice_slot !== e.slot) begin
                    $error("voice_slot exp %0d got %0d", e.slot, o_voice_slot); errors++;
                end
                if (o_voice_tag !== e.tag) begin
                    $error("voice_tag exp %0d got %0d", e.tag, o_voice_tag); errors++;
                end
                if (o_zone !== e.zone) begin
                    $error("zone exp %0d got %0d", e.zone, o_zone); errors++;
                end
                if (o_pitch !== e.pitch) begin
                    $error("pitch exp %0d got %0d", $signed(e.pitch), o_pitch); errors++;
                end
                if (o_pressure !== e.pressure) begin
                    $error("pressure exp %0d got %0d", e.pressure, o_pressure); errors++;
                end
                if (o_timbre !== e.timbre) begin
                    $error("timbre exp %0d got %0d", e.timbre, o_timbre); errors++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0h got %0h", e.last, o_last); errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void add_msg(logic [3:0] kind, logic [3:0] ch, int d1, int d2);
        t_msg m;
        m.status = {kind, ch};
        m.d1 = d1[6:0];
        m.d2 = d2[6:0];
        pending_msgs.push_back(m);
    endfunction

    // Wait until the block has drained every request and result.
    task automatic drain();
        while (pending_msgs.size() > 0 || start || busy || expected_events.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // One register write; the enable is low for a cycle before the next write.
    task automatic write_cfg(logic idx, logic [6:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        if (idx == CFG_PRESSURE) pr_ctl = value;
        else tb_ctl = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random message, mostly well-formed voice traffic on a few channels.
    function automatic void add_random();
        logic [3:0] ch;
        int r;
        ch = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
        r = $urandom_range(0, 99);
        if (r < 28) add_msg(KIND_ON, ch, $urandom_range(0, 127), $urandom_range(0, 127));
        else if (r < 45) begin
            int v;
            v = $urandom_range(0, NVOICE - 1);
            if (v_on[v] && $urandom_range(0, 3) != 0)
                add_msg(KIND_OFF, v_ch[v], int'(v_key[v]), 0);
            else add_msg(KIND_OFF, ch, $urandom_range(0, 127), $urandom_range(0, 127));
        end else if (r < 55) begin
            int v;
            v = $urandom_range(0, NVOICE - 1);
            if (v_on[v])
                add_msg(KIND_POLY, v_ch[v], int'(v_key[v]), $urandom_range(0, 127));
            else add_msg(KIND_POLY, ch, $urandom_range(0, 127), $urandom_range(0, 127));
        end else if (r < 65) add_msg(KIND_BEND, ch, $urandom_range(0, 127), $urandom_range(0, 127));
        else if (r < 85) begin
            int c;
            case ($urandom_range(0, 7))
                0: c = int'(pr_ctl);
                1: c = int'(pr_ctl) + 32;
                2: c = int'(tb_ctl);
                3: c = int'(tb_ctl) + 32;
                4: c = int'(CC_RPN_LSB);
                5: c = int'(CC_RPN_MSB);
                6: c = ($urandom_range(0, 1) == 0) ? int'(CC_DATA_MSB) : int'(CC_DATA_LSB);
                default: c = $urandom_range(0, 127);
            endcase
            add_msg(KIND_CTRL, ch, c, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 127));
        end else begin
            t_msg m;
            m.status = 8'($urandom);
            m.d1 = 7'($urandom);
            m.d2 = 7'($urandom);
            pending_msgs.push_back(m);
        end
    endfunction

    initial begin
        logic [6:0] settings[5][2];
        settings = '{'{7'd1, 7'd74}, '{7'd0, 7'd127}, '{7'd95, 7'd2},
                     '{7'd11, 7'd11}, '{7'd127, 7'd0}};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        i_status_byte = '0;
        i_data_one = '0;
        i_data_two = '0;
        errors = 0;
        cycles = 0;
        hold_sender = 1'b0;
        pr_ctl = '0;
        tb_ctl = '0;
        tag_next = '0;
        for (int v = 0; v < NVOICE; v++) v_on[v] = 1'b0;
        for (int c = 0; c < 16; c++) begin
            ch_bend[c] = 0;
            ch_rpn[c] = '0;
            ch_data[c] = '0;
            ch_range[c] = int'(RANGE_RESET);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_cfg(CFG_PRESSURE, 7'd1);
        write_cfg(CFG_TIMBRE, 7'd74);

        // Directed: extremes, every kind, table full, bend range changes.
        add_msg(KIND_ON, 4'd0, 0, 0);
        add_msg(KIND_ON, 4'd15, 127, 127);
        add_msg(KIND_BEND, 4'd15, 127, 127);
        add_msg(KIND_BEND, 4'd0, 0, 0);
        add_msg(KIND_CTRL, 4'd0, int'(CC_DATA_LSB), 127);
        add_msg(KIND_CTRL, 4'd0, int'(CC_DATA_MSB), 127);
        add_msg(KIND_CTRL, 4'd15, int'(CC_RPN_MSB), 1);
        add_msg(KIND_CTRL, 4'd15, int'(CC_DATA_MSB), 5);
        add_msg(KIND_CTRL, 4'd0, 33, 127);
        add_msg(KIND_CTRL, 4'd0, 1, 127);
        add_msg(KIND_CTRL, 4'd0, 106, 5);
        add_msg(KIND_CTRL, 4'd0, 74, 64);
        add_msg(KIND_POLY, 4'd15, 127, 127);
        add_msg(KIND_POLY, 4'd15, 3, 9);
        add_msg(KIND_OFF, 4'd0, 0, 0);
        add_msg(KIND_OFF, 4'd0, 0, 0);
        add_msg(KIND_PROG, 4'd1, 5, 5);
        add_msg(KIND_SYS, 4'd0, 5, 5);
        for (int i = 0; i < 17; i++) add_msg(KIND_ON, 4'd2, i, 100);
        add_msg(KIND_BEND, 4'd2, 0, 64);
        drain();

        // Random phases, one per controller setting.
        foreach (settings[p]) begin
            write_cfg(CFG_PRESSURE, settings[p][0]);
            write_cfg(CFG_TIMBRE, settings[p][1]);
            for (int i = 0; i < 55; i++) begin
                add_random();
                if (i == 30) begin
                    drain();
                    hold_sender = 1'b1;
                    hold_sender = 1'b0;
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
